// ===== rtl/cbt_pkg.sv =====
`default_nettype none
package cbt_pkg;

  // Field widths of the transaction ports, datapath widths and tanh table size
  localparam int REQ_W    = 2;
  localparam int FILT_W   = 4;
  localparam int CHAN_W   = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 32;
  localparam int ROM_DEPTH = 1025;
  localparam int ROM_AW   = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_WEIGHT  = 2'd1,
    REQ_BIAS    = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_COLS     = 2'd2,
    CFG_CHANNELS = 2'd3
  } cfg_index_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic data_valid;
    logic prod_valid;
    logic finish;
  } mac_ctrl_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] activation;
    logic                     clipped;
  } mac_result_t;

  typedef logic [DATA_W-1:0] tanh_rom_t [0:ROM_DEPTH-1];

  // Shift-subtract division for table generation; returns {quotient, remainder}
  function automatic logic [127:0] divmod64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // round(32767*tanh(i/128)) using e^(-2x) in Q2.62
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t    rom;
    logic [63:0]  one62;
    logic [63:0]  term;
    logic [63:0]  c;
    logic [63:0]  y;
    logic [63:0]  n2;
    logic [63:0]  d2;
    logic [63:0]  num;
    logic [63:0]  q;
    logic [63:0]  rm;
    logic [127:0] p;
    logic [127:0] qr;
    one62 = 64'h4000_0000_0000_0000;
    term  = one62;
    c     = one62;
    y     = one62;
    for (int k = 1; k <= 10; k++) begin
      qr   = divmod64(term, 64'(64 * k));
      term = qr[127:64];
      if (k[0]) begin
        c = c - term;
      end else begin
        c = c + term;
      end
    end
    for (int i = 0; i < ROM_DEPTH; i++) begin
      n2  = (one62 - y) >> 14;
      d2  = (one62 + y) >> 14;
      num = 64'd32767 * n2;
      qr  = divmod64(num, d2);
      q   = qr[127:64];
      rm  = qr[63:0];
      rom[i] = DATA_W'(q + (((rm << 1) >= d2) ? 64'd1 : 64'd0));
      p = {64'd0, y} * {64'd0, c};
      y = p[125:62] + {63'd0, p[61]};
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage
`default_nettype wire

// ===== rtl/cbt_store.sv =====
`default_nettype none
module cbt_store #(
  parameter int S_DEPTH = 16384,
  parameter int W_DEPTH = 3136,
  parameter int B_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic [cbt_pkg::DATA_W-1:0]    wdata,
  input  wire logic                          s_we,
  input  wire logic [((S_DEPTH>1)?$clog2(S_DEPTH):1)-1:0] s_waddr,
  input  wire logic [((S_DEPTH>1)?$clog2(S_DEPTH):1)-1:0] s_raddr,
  input  wire logic                          w_we,
  input  wire logic [((W_DEPTH>1)?$clog2(W_DEPTH):1)-1:0] w_waddr,
  input  wire logic [((W_DEPTH>1)?$clog2(W_DEPTH):1)-1:0] w_raddr,
  input  wire logic                          b_we,
  input  wire logic [((B_DEPTH>1)?$clog2(B_DEPTH):1)-1:0] b_waddr,
  input  wire logic [((B_DEPTH>1)?$clog2(B_DEPTH):1)-1:0] b_raddr,
  output logic      [cbt_pkg::DATA_W-1:0]    s_rdata,
  output logic      [cbt_pkg::DATA_W-1:0]    w_rdata,
  output logic      [cbt_pkg::DATA_W-1:0]    b_rdata
);
  import cbt_pkg::*;

  logic [DATA_W-1:0] s_mem [0:S_DEPTH-1];
  logic [DATA_W-1:0] w_mem [0:W_DEPTH-1];
  logic [DATA_W-1:0] b_mem [0:B_DEPTH-1];

  // Sample store: one write, one registered read
  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_waddr] <= wdata;
    end
    s_rdata <= s_mem[s_raddr];
  end

  // Kernel weight store
  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= wdata;
    end
    w_rdata <= w_mem[w_raddr];
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= wdata;
    end
    b_rdata <= b_mem[b_raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/cbt_mac.sv =====
`default_nettype none
module cbt_mac (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cbt_pkg::mac_ctrl_t         ctrl,
  input  wire logic [cbt_pkg::DATA_W-1:0] s_data,
  input  wire logic [cbt_pkg::DATA_W-1:0] w_data,
  input  wire logic [cbt_pkg::DATA_W-1:0] b_data,
  output cbt_pkg::mac_result_t            res
);
  import cbt_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum_r;
  logic                     sum_v_r;
  logic                     rom_v_r;
  logic [DATA_W-1:0]        rom_q_r;
  logic                     neg_r;
  logic                     clip_r;
  logic                     res_v_r;
  logic signed [DATA_W-1:0] act_r;
  logic                     res_clip_r;

  logic signed [ACC_W-1:0]  bias_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic                     over_hi;
  logic                     over_lo;
  logic signed [ROM_AW:0]   idx;
  logic [ROM_AW-1:0]        mag;

  // Multiply registered samples and weights
  always_ff @(posedge clk) begin
    if (ctrl.data_valid) begin
      prod_r <= PROD_W'(signed'(s_data) * signed'(w_data));
    end
  end

  // Accumulate products, clear at start of a transaction
  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.prod_valid) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign bias_ext = ACC_W'(signed'(b_data)) <<< 12;

  // Add bias
  always_ff @(posedge clk) begin
    sum_r <= acc_r + bias_ext;
  end

  // Scale to tanh argument and saturate
  always_comb begin
    shifted = sum_r >>> 17;
    over_hi = shifted > ACC_W'(1023);
    over_lo = shifted < -ACC_W'(1024);
    priority if (over_hi) begin
      idx = (ROM_AW+1)'(1023);
    end else if (over_lo) begin
      idx = -(ROM_AW+1)'(1024);
    end else begin
      idx = shifted[ROM_AW:0];
    end
    mag = idx[ROM_AW] ? ROM_AW'(-idx) : idx[ROM_AW-1:0];
  end

  // Look up tanh magnitude
  always_ff @(posedge clk) begin
    rom_q_r <= TANH_ROM[mag];
    neg_r   <= idx[ROM_AW];
    clip_r  <= over_hi || over_lo;
  end

  // Apply sign
  always_ff @(posedge clk) begin
    act_r      <= neg_r ? -signed'(rom_q_r) : signed'(rom_q_r);
    res_clip_r <= clip_r;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
      rom_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      sum_v_r <= ctrl.finish;
      rom_v_r <= sum_v_r;
      res_v_r <= rom_v_r;
    end
  end

  assign res.valid      = res_v_r;
  assign res.activation = act_r;
  assign res.clipped    = res_clip_r;

endmodule
`default_nettype wire

// ===== rtl/conv2d_bias_tanh_unit.sv =====
`default_nettype none
// Loads give no result; busy stays low.
// A compute walks every channel and kernel position before its result strobe, with
// one sample/weight memory read pair and one multiply-accumulate per cycle.
// An out-of-range compute gives its result strobe in the cycle after start.
// One good compute in flight; next start taken the cycle after its strobe; results never stall.
// rst_n is synchronous: control and config reset; counters, datapath and memories stay undefined.
module conv2d_bias_tanh_unit #(
  parameter int MAX_RADIUS   = 3,
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_FILTERS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [cbt_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [cbt_pkg::FILT_W-1:0]       in_filter_index,
  input  wire logic [cbt_pkg::CHAN_W-1:0]       in_channel,
  input  wire logic [cbt_pkg::POS_W-1:0]        in_row,
  input  wire logic [cbt_pkg::POS_W-1:0]        in_col,
  input  wire logic signed [cbt_pkg::DATA_W-1:0] in_value,
  output logic                                  out_valid,
  output logic signed [cbt_pkg::DATA_W-1:0]     out_activation,
  output logic                                  out_clipped,
  output logic                                  out_bad_request,
  input  wire logic                             cfg_we,
  input  wire logic [cbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cbt_pkg::*;

  localparam int KSIDE   = 2 * MAX_RADIUS + 1;
  localparam int KAREA   = KSIDE * KSIDE;
  localparam int PLANE   = MAX_ROWS * MAX_COLS;
  localparam int S_DEPTH = MAX_CHANNELS * PLANE;
  localparam int W_DEPTH = MAX_FILTERS * MAX_CHANNELS * KAREA;
  localparam int B_DEPTH = MAX_FILTERS;
  localparam int SAW = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int KCW = (KSIDE > 1) ? $clog2(KSIDE) : 1;
  localparam int CCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNW = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [1:0]      radius_r;
  logic [6:0]      rows_r, cols_r;
  logic [2:0]      chans_r;
  logic [KCW-1:0]  kx_r, kx_nxt, ky_r, ky_nxt;
  logic [CCW-1:0]  ch_r, ch_nxt;
  logic [SAW-1:0]  s_chan_r, s_chan_nxt, s_line_r, s_line_nxt, s_addr_r, s_addr_nxt;
  logic [WAW-1:0]  w_chan_r, w_chan_nxt, w_line_r, w_line_nxt, w_addr_r, w_addr_nxt;
  logic [BAW-1:0]  b_addr_r, b_addr_nxt;
  logic            v1_r, v2_r;
  logic            bad_r, bad_nxt;

  int              r_eff, rows_eff, cols_eff, chans_int;
  logic [KCW-1:0]  span;
  logic [CNW-1:0]  chans_eff;
  logic            accept, is_compute, bad;
  logic            s_we, w_we, b_we;
  logic [SAW-1:0]  s_waddr, s_start;
  logic [WAW-1:0]  w_waddr, w_start;
  logic [DATA_W-1:0] s_rdata, w_rdata, b_rdata;
  mac_ctrl_t       ctrl;
  mac_result_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd2;
      rows_r   <= 7'd64;
      cols_r   <= 7'd64;
      chans_r  <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RADIUS:   radius_r <= cfg_wdata[1:0];
        CFG_ROWS:     rows_r   <= cfg_wdata;
        CFG_COLS:     cols_r   <= cfg_wdata;
        CFG_CHANNELS: chans_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the built sizes and check the request
  always_comb begin
    r_eff     = (int'(radius_r) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_r);
    rows_eff  = (int'(rows_r) > MAX_ROWS) ? MAX_ROWS : int'(rows_r);
    cols_eff  = (int'(cols_r) > MAX_COLS) ? MAX_COLS : int'(cols_r);
    chans_int = (int'(chans_r) > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_r);
    span      = KCW'(2 * r_eff);
    chans_eff = CNW'(chans_int);
    bad = (int'(in_filter_index) >= MAX_FILTERS) ||
          (int'(in_row) + 2 * r_eff >= rows_eff) ||
          (int'(in_col) + 2 * r_eff >= cols_eff);
  end

  assign accept     = start && !busy;
  assign is_compute = (req_type_t'(in_req_type) == REQ_COMPUTE);

  // Load writes go straight to the memories
  always_comb begin
    s_we = accept && (req_type_t'(in_req_type) == REQ_SAMPLE) &&
           (int'(in_channel) < MAX_CHANNELS) && (int'(in_row) < MAX_ROWS) &&
           (int'(in_col) < MAX_COLS);
    w_we = accept && (req_type_t'(in_req_type) == REQ_WEIGHT) &&
           (int'(in_filter_index) < MAX_FILTERS) && (int'(in_channel) < MAX_CHANNELS) &&
           (int'(in_row) < KSIDE) && (int'(in_col) < KSIDE);
    b_we = accept && (req_type_t'(in_req_type) == REQ_BIAS) &&
           (int'(in_filter_index) < MAX_FILTERS);
    s_waddr = SAW'(in_channel) * SAW'(PLANE) + SAW'(in_row) * SAW'(MAX_COLS) +
              SAW'(in_col);
    w_waddr = WAW'(in_filter_index) * WAW'(MAX_CHANNELS * KAREA) +
              WAW'(in_channel) * WAW'(KAREA) + WAW'(in_row) * WAW'(KSIDE) +
              WAW'(in_col);
    s_start = SAW'(in_row) * SAW'(MAX_COLS) + SAW'(in_col);
    w_start = WAW'(in_filter_index) * WAW'(MAX_CHANNELS * KAREA);
  end

  // Sequencer: flag bad computes, walk channels, kernel rows and kernel columns, then wait for the result
  always_comb begin
    state_nxt  = state_r;
    kx_nxt     = kx_r;
    ky_nxt     = ky_r;
    ch_nxt     = ch_r;
    s_chan_nxt = s_chan_r;
    s_line_nxt = s_line_r;
    s_addr_nxt = s_addr_r;
    w_chan_nxt = w_chan_r;
    w_line_nxt = w_line_r;
    w_addr_nxt = w_addr_r;
    b_addr_nxt = b_addr_r;
    bad_nxt    = 1'b0;
    ctrl.clear = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_compute) begin
          if (bad) begin
            bad_nxt = 1'b1;
          end else begin
            ctrl.clear = 1'b1;
            kx_nxt     = '0;
            ky_nxt     = '0;
            ch_nxt     = '0;
            s_chan_nxt = s_start;
            s_line_nxt = s_start;
            s_addr_nxt = s_start;
            w_chan_nxt = w_start;
            w_line_nxt = w_start;
            w_addr_nxt = w_start;
            b_addr_nxt = BAW'(in_filter_index);
            state_nxt  = (chans_eff == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (kx_r != span) begin
          kx_nxt     = kx_r + 1'b1;
          s_addr_nxt = s_addr_r + 1'b1;
          w_addr_nxt = w_addr_r + 1'b1;
        end else begin
          kx_nxt = '0;
          if (ky_r != span) begin
            ky_nxt     = ky_r + 1'b1;
            s_line_nxt = s_line_r + SAW'(MAX_COLS);
            s_addr_nxt = s_line_r + SAW'(MAX_COLS);
            w_line_nxt = w_line_r + WAW'(KSIDE);
            w_addr_nxt = w_line_r + WAW'(KSIDE);
          end else begin
            ky_nxt = '0;
            if (CNW'(ch_r) == chans_eff - 1'b1) begin
              state_nxt = ST_DRAIN;
            end else begin
              ch_nxt     = ch_r + 1'b1;
              s_chan_nxt = s_chan_r + SAW'(PLANE);
              s_line_nxt = s_chan_r + SAW'(PLANE);
              s_addr_nxt = s_chan_r + SAW'(PLANE);
              w_chan_nxt = w_chan_r + WAW'(KAREA);
              w_line_nxt = w_chan_r + WAW'(KAREA);
              w_addr_nxt = w_chan_r + WAW'(KAREA);
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (res.valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    ctrl.data_valid = v1_r;
    ctrl.prod_valid = v2_r;
    ctrl.finish     = (state_r == ST_FIN);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_RUN);
      v2_r    <= v1_r;
      bad_r   <= bad_nxt;
    end
  end

  // Counters and addresses
  always_ff @(posedge clk) begin
    kx_r     <= kx_nxt;
    ky_r     <= ky_nxt;
    ch_r     <= ch_nxt;
    s_chan_r <= s_chan_nxt;
    s_line_r <= s_line_nxt;
    s_addr_r <= s_addr_nxt;
    w_chan_r <= w_chan_nxt;
    w_line_r <= w_line_nxt;
    w_addr_r <= w_addr_nxt;
    b_addr_r <= b_addr_nxt;
  end

  cbt_store #(
    .S_DEPTH (S_DEPTH),
    .W_DEPTH (W_DEPTH),
    .B_DEPTH (B_DEPTH)
  ) u_store (
    .clk     (clk),
    .wdata   (in_value),
    .s_we    (s_we),
    .s_waddr (s_waddr),
    .s_raddr (s_addr_r),
    .w_we    (w_we),
    .w_waddr (w_waddr),
    .w_raddr (w_addr_r),
    .b_we    (b_we),
    .b_waddr (BAW'(in_filter_index)),
    .b_raddr (b_addr_r),
    .s_rdata (s_rdata),
    .w_rdata (w_rdata),
    .b_rdata (b_rdata)
  );

  cbt_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .s_data (s_rdata),
    .w_data (w_rdata),
    .b_data (b_rdata),
    .res    (res)
  );

  // Result ports
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = res.valid || bad_r;
  assign out_activation  = bad_r ? '0 : res.activation;
  assign out_clipped     = bad_r ? 1'b0 : res.clipped;
  assign out_bad_request = bad_r;

endmodule
`default_nettype wire

// ===== rtl/cbt_checker.sv =====
`default_nettype none
module cbt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [cbt_pkg::REQ_W-1:0]         in_req_type,
  input wire logic                              out_valid,
  input wire logic signed [cbt_pkg::DATA_W-1:0] out_activation,
  input wire logic                              out_clipped,
  input wire logic                              out_bad_request
);
  import cbt_pkg::*;

  // A flagged request carries a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_activation == '0 && !out_clipped)
    else $error("flagged result not zero");

  // A load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type != REQ_COMPUTE |=> !out_valid)
    else $error("result after a load");

  // A compute either starts work or answers at once
  a_compute_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_COMPUTE |=> busy || out_valid)
    else $error("compute transaction dropped");

  // Work ends only right after its result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("busy fell without a result");

endmodule

bind conv2d_bias_tanh_unit cbt_checker u_cbt_checker (.*);
`default_nettype wire
